// File: hw/rtl/wsd_pkg.sv
// shared types and constants for the websocket frame deframer
// used by wsd_parser, wsd_skid and websocket_frame_deframer; no dependencies
package wsd_pkg;

	// stream byte, length and register widths
	localparam int unsigned ByteW  = 8;
	localparam int unsigned LimitW = 16;
	localparam int unsigned KindW  = 3;

	// size limit after reset
	localparam logic [LimitW-1:0] LimitReset = 16'hffff;

	// lead byte of a close frame (fin set, opcode close)
	localparam logic [ByteW-1:0] CloseLead = 8'h88;

	// low 7 bits of the length byte: largest direct length, and the code for a 16-bit extended length
	localparam logic [6:0] Len7Max   = 7'd125;
	localparam logic [6:0] Len7Ext16 = 7'd126;

	// header lengths for the three length forms
	localparam logic [3:0] HdrLenShort = 4'd6;
	localparam logic [3:0] HdrLenExt16 = 4'd8;
	localparam logic [3:0] HdrLenExt64 = 4'd14;

	// extended length byte counts
	localparam logic [3:0] ExtCnt16 = 4'd2;
	localparam logic [3:0] ExtCnt64 = 4'd8;
	localparam logic [3:0] ExtCntHi = 4'd4;

	// parser phase
	typedef enum logic [2:0] {
		PH_LEAD,
		PH_LEN,
		PH_EXT,
		PH_MASK,
		PH_DATA
	} phase_t;

	// result kind
	typedef enum logic [KindW-1:0] {
		K_HEADER  = 3'd0,
		K_PAYLOAD = 3'd1,
		K_EMPTY   = 3'd2,
		K_CLOSE   = 3'd3,
		K_ERROR   = 3'd4,
		K_DROP    = 3'd5
	} kind_t;

	// one result beat
	typedef struct packed {
		kind_t            kind;
		logic [ByteW-1:0] payload_byte;
		logic             last_byte;
		logic [ByteW-1:0] frame_lead;
	} res_t;

endpackage

// File: hw/rtl/websocket_frame_deframer.sv
// websocket client-to-server frame deframer top level
// depends on wsd_pkg, wsd_parser and wsd_skid
//
// Takes one stream byte per beat and returns exactly one result beat for each, in order.
// A byte is taken in every clock cycle while s_tready is high; its result is registered in the
// output register, or in the skid stage while the output is stalled. s_tready is driven from a
// register and is low only while the skid stage holds a result, so the skid stage takes the
// result of a byte accepted during a stall. frame_size_limit is written through cfg_wen and
// cfg_wdata only while the block is idle; the user must keep to this, the block does not enforce it.
// After an oversize frame or a close, every further byte returns a dropped result until reset.
module websocket_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [15:0] cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // byte_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // payload_byte [7:0], frame_lead [15:8]
	output logic [2:0]  m_tuser,   // kind
	output logic        m_tlast
);

	wsd_pkg::res_t res;
	wsd_pkg::res_t out_res;
	logic          fire;

	assign fire = s_tvalid && s_tready;

	// header parser and unmasker
	wsd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.byte_in   (s_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.res       (res)
	);

	// result register and skid stage
	wsd_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_res    (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// output packing
	assign m_tdata = {out_res.frame_lead, out_res.payload_byte};
	assign m_tuser = out_res.kind;
	assign m_tlast = out_res.last_byte;

endmodule

// File: hw/rtl/wsd_parser.sv
// frame header parser and payload unmasker, one stream byte per beat
// depends on wsd_pkg
module wsd_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              fire,
	input  logic [wsd_pkg::ByteW-1:0]         byte_in,
	input  logic                              cfg_wen,
	input  logic [wsd_pkg::LimitW-1:0]        cfg_wdata,
	output wsd_pkg::res_t                     res
);

	wsd_pkg::phase_t phase_q, phase_d;
	logic [7:0]  lead_q, lead_d;
	logic [3:0]  ext_cnt_q, ext_cnt_d;
	logic        hi_nz_q, hi_nz_d;
	logic [31:0] plen_q, plen_d;
	logic [3:0]  hlen_q, hlen_d;
	logic [31:0] mkey_q, mkey_d;
	logic [1:0]  midx_q, midx_d;
	logic [15:0] left_q, left_d;
	logic        stopped_q, stopped_d;
	logic [15:0] limit_q;

	logic [6:0]  len7;
	logic [16:0] total;
	logic        oversize;
	logic        mask_done;
	logic        data_last;
	logic        is_close;
	logic [3:0]  ext_cnt_dec;
	logic [7:0]  mask_byte;

	// shared conditions
	assign len7        = byte_in[6:0];
	assign total       = {1'b0, plen_q[15:0]} + {13'd0, hlen_q};
	assign oversize    = hi_nz_q || (plen_q[31:16] != 16'd0) || (total >= {1'b0, limit_q});
	assign mask_done   = (midx_q == 2'd3);
	assign data_last   = (left_q <= 16'd1);
	assign is_close    = (lead_q == wsd_pkg::CloseLead);
	assign ext_cnt_dec = ext_cnt_q - 4'd1;
	assign mask_byte   = mkey_q[(5'd31 - {midx_q, 3'b000}) -: 8];

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (!stopped_q) begin
			unique case (phase_q)
				wsd_pkg::PH_LEAD: phase_d = wsd_pkg::PH_LEN;
				wsd_pkg::PH_LEN: begin
					if (len7 <= wsd_pkg::Len7Max) phase_d = wsd_pkg::PH_MASK;
					else phase_d = wsd_pkg::PH_EXT;
				end
				wsd_pkg::PH_EXT: begin
					if (ext_cnt_dec == 4'd0) phase_d = wsd_pkg::PH_MASK;
				end
				wsd_pkg::PH_MASK: begin
					if (mask_done && !oversize) begin
						if (plen_q == 32'd0) phase_d = wsd_pkg::PH_LEAD;
						else phase_d = wsd_pkg::PH_DATA;
					end
				end
				wsd_pkg::PH_DATA: begin
					if (data_last) phase_d = wsd_pkg::PH_LEAD;
				end
				default: phase_d = wsd_pkg::PH_LEAD;
			endcase
		end
	end

	// datapath register updates
	always_comb begin
		lead_d    = lead_q;
		ext_cnt_d = ext_cnt_q;
		hi_nz_d   = hi_nz_q;
		plen_d    = plen_q;
		hlen_d    = hlen_q;
		mkey_d    = mkey_q;
		midx_d    = midx_q;
		left_d    = left_q;
		stopped_d = stopped_q;
		if (!stopped_q) begin
			unique case (phase_q)
				wsd_pkg::PH_LEAD: lead_d = byte_in;
				wsd_pkg::PH_LEN: begin
					hi_nz_d = 1'b0;
					mkey_d  = 32'd0;
					midx_d  = 2'd0;
					if (len7 <= wsd_pkg::Len7Max) begin
						plen_d    = {25'd0, len7};
						hlen_d    = wsd_pkg::HdrLenShort;
						ext_cnt_d = 4'd0;
					end else if (len7 == wsd_pkg::Len7Ext16) begin
						plen_d    = 32'd0;
						hlen_d    = wsd_pkg::HdrLenExt16;
						ext_cnt_d = wsd_pkg::ExtCnt16;
					end else begin
						plen_d    = 32'd0;
						hlen_d    = wsd_pkg::HdrLenExt64;
						ext_cnt_d = wsd_pkg::ExtCnt64;
					end
				end
				wsd_pkg::PH_EXT: begin
					if (ext_cnt_q > wsd_pkg::ExtCntHi) begin
						if (byte_in != 8'd0) hi_nz_d = 1'b1;
					end else begin
						plen_d = {plen_q[23:0], byte_in};
					end
					ext_cnt_d = ext_cnt_dec;
				end
				wsd_pkg::PH_MASK: begin
					mkey_d = {mkey_q[23:0], byte_in};
					midx_d = midx_q + 2'd1;
					if (mask_done) begin
						if (oversize) stopped_d = 1'b1;
						else if (plen_q == 32'd0) begin
							if (is_close) stopped_d = 1'b1;
						end else begin
							left_d = plen_q[15:0];
						end
					end
				end
				wsd_pkg::PH_DATA: begin
					midx_d = midx_q + 2'd1;
					left_d = left_q - 16'd1;
					if (is_close && data_last) stopped_d = 1'b1;
				end
				default: ;
			endcase
		end
	end

	// result for the current beat
	always_comb begin
		res.kind         = wsd_pkg::K_HEADER;
		res.payload_byte = 8'd0;
		res.last_byte    = 1'b0;
		res.frame_lead   = lead_d;
		if (stopped_q) begin
			res.kind = wsd_pkg::K_DROP;
		end else begin
			unique case (phase_q)
				wsd_pkg::PH_MASK: begin
					if (mask_done) begin
						if (oversize) res.kind = wsd_pkg::K_ERROR;
						else if (plen_q == 32'd0) begin
							if (is_close) res.kind = wsd_pkg::K_CLOSE;
							else res.kind = wsd_pkg::K_EMPTY;
						end
					end
				end
				wsd_pkg::PH_DATA: begin
					if (is_close) begin
						if (data_last) begin
							res.kind      = wsd_pkg::K_CLOSE;
							res.last_byte = 1'b1;
						end else begin
							res.kind = wsd_pkg::K_DROP;
						end
					end else begin
						res.kind         = wsd_pkg::K_PAYLOAD;
						res.payload_byte = byte_in ^ mask_byte;
						res.last_byte    = data_last;
					end
				end
				default: ;
			endcase
		end
	end

	// state registers, updated on each accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= wsd_pkg::PH_LEAD;
			lead_q    <= 8'd0;
			ext_cnt_q <= 4'd0;
			hi_nz_q   <= 1'b0;
			plen_q    <= 32'd0;
			hlen_q    <= 4'd0;
			mkey_q    <= 32'd0;
			midx_q    <= 2'd0;
			left_q    <= 16'd0;
			stopped_q <= 1'b0;
		end else if (fire) begin
			phase_q   <= phase_d;
			lead_q    <= lead_d;
			ext_cnt_q <= ext_cnt_d;
			hi_nz_q   <= hi_nz_d;
			plen_q    <= plen_d;
			hlen_q    <= hlen_d;
			mkey_q    <= mkey_d;
			midx_q    <= midx_d;
			left_q    <= left_d;
			stopped_q <= stopped_d;
		end
	end

	// size limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= wsd_pkg::LimitReset;
		end else if (cfg_wen) begin
			limit_q <= cfg_wdata;
		end
	end

endmodule

// File: hw/rtl/wsd_skid.sv
// output register with skid stage for result beats
// depends on wsd_pkg
module wsd_skid (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  wsd_pkg::res_t in_res,
	output logic          out_valid,
	input  logic          out_ready,
	output wsd_pkg::res_t out_res
);

	logic          out_valid_q;
	logic          skid_valid_q;
	wsd_pkg::res_t out_q;
	wsd_pkg::res_t skid_q;
	logic          in_fire;
	logic          out_free;

	assign in_ready  = !skid_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_res   = out_q;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_fire;
			skid_valid_q <= 1'b0;
		end else if (in_fire) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) out_q <= skid_q;
			else if (in_fire) out_q <= in_res;
		end else if (in_fire) begin
			skid_q <= in_res;
		end
	end

endmodule
